// ----- hw/rtl/aob_pkg.sv -----
// ----------------------------------------------------------------------------
// Alpha-over blend package
// Widths, constants and operand types shared by the blend front end, the
// divider lanes and the top level.
// ----------------------------------------------------------------------------
package aob_pkg;

    localparam int CH_W         = 8;
    localparam int T_W          = 16;
    localparam int A_W          = 24;
    localparam int N_W          = 32;
    localparam int QUOT_W       = 8;
    localparam int FRONT_STAGES = 3;
    localparam int DIV_STAGES   = QUOT_W;
    localparam int RECIP_W      = 25;
    localparam int RECIP_SHIFT  = 40;

    localparam logic [CH_W-1:0] FULL    = 8'd255;
    localparam logic [T_W-1:0]  FULL_SQ = 16'd65025;

    // Rounded-up reciprocal of 65025 scaled by 2**40, exact for every
    // alpha numerator below 2**24.
    localparam logic [RECIP_W-1:0] ALPHA_RECIP = 25'd16909061;

    typedef logic [CH_W-1:0] chan_t;

    typedef struct packed {
        logic [A_W-1:0] alpha_num;
        logic [N_W-1:0] num_red;
        logic [N_W-1:0] num_green;
        logic [N_W-1:0] num_blue;
    } operands_t;

endpackage

// ----- hw/rtl/aob_front.sv -----
// ----------------------------------------------------------------------------
// Alpha-over blend front end
// Three register stages that form the output alpha numerator and the three
// colour numerators from one pixel pair.
// ----------------------------------------------------------------------------
module aob_front (
    input  logic                 aclk,
    input  logic                 en,
    input  aob_pkg::chan_t       bottom_red,
    input  aob_pkg::chan_t       bottom_green,
    input  aob_pkg::chan_t       bottom_blue,
    input  aob_pkg::chan_t       bottom_alpha,
    input  aob_pkg::chan_t       top_red,
    input  aob_pkg::chan_t       top_green,
    input  aob_pkg::chan_t       top_blue,
    input  aob_pkg::chan_t       top_alpha,
    input  aob_pkg::chan_t       layer_opacity,
    output aob_pkg::operands_t   operands
);

    // Stage 1: effective top alpha and bottom colour times bottom alpha.
    logic [aob_pkg::T_W-1:0] t1_reg;
    logic [aob_pkg::T_W-1:0] bw_red_reg;
    logic [aob_pkg::T_W-1:0] bw_green_reg;
    logic [aob_pkg::T_W-1:0] bw_blue_reg;
    aob_pkg::chan_t          ba1_reg;
    aob_pkg::chan_t          tr1_reg;
    aob_pkg::chan_t          tg1_reg;
    aob_pkg::chan_t          tb1_reg;

    // Stage 2: products with the effective top alpha and its complement.
    logic [aob_pkg::T_W-1:0] t2_reg;
    logic [aob_pkg::A_W-1:0] pt_red_reg;
    logic [aob_pkg::A_W-1:0] pt_green_reg;
    logic [aob_pkg::A_W-1:0] pt_blue_reg;
    logic [aob_pkg::N_W-1:0] pb_red_reg;
    logic [aob_pkg::N_W-1:0] pb_green_reg;
    logic [aob_pkg::N_W-1:0] pb_blue_reg;
    logic [aob_pkg::A_W-1:0] pa_reg;

    logic [aob_pkg::T_W-1:0] dt_next;

    aob_pkg::operands_t operands_reg;
    aob_pkg::operands_t operands_next;

    assign dt_next = aob_pkg::FULL_SQ - t1_reg;

    // Times 255 as a shift and subtract.
    function automatic logic [aob_pkg::N_W-1:0] times_full(
        input logic [aob_pkg::A_W-1:0] v
    );
        return {v, 8'b0} - {8'b0, v};
    endfunction

    always_comb begin
        operands_next.num_red   = times_full(pt_red_reg) + pb_red_reg;
        operands_next.num_green = times_full(pt_green_reg) + pb_green_reg;
        operands_next.num_blue  = times_full(pt_blue_reg) + pb_blue_reg;
        operands_next.alpha_num = aob_pkg::A_W'({t2_reg, 8'b0} - {8'b0, t2_reg})
                                  + pa_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg       <= top_alpha * layer_opacity;
            bw_red_reg   <= bottom_red * bottom_alpha;
            bw_green_reg <= bottom_green * bottom_alpha;
            bw_blue_reg  <= bottom_blue * bottom_alpha;
            ba1_reg      <= bottom_alpha;
            tr1_reg      <= top_red;
            tg1_reg      <= top_green;
            tb1_reg      <= top_blue;

            t2_reg       <= t1_reg;
            pt_red_reg   <= tr1_reg * t1_reg;
            pt_green_reg <= tg1_reg * t1_reg;
            pt_blue_reg  <= tb1_reg * t1_reg;
            pb_red_reg   <= bw_red_reg * dt_next;
            pb_green_reg <= bw_green_reg * dt_next;
            pb_blue_reg  <= bw_blue_reg * dt_next;
            pa_reg       <= ba1_reg * dt_next;

            operands_reg <= operands_next;
        end
    end

    assign operands = operands_reg;

endmodule

// ----- hw/rtl/aob_div_lane.sv -----
// ----------------------------------------------------------------------------
// Alpha-over blend divider lane
// Pipelined restoring divider, one quotient bit per stage, for numerators
// known to be below 256 times the divisor.
// ----------------------------------------------------------------------------
module aob_div_lane (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [aob_pkg::N_W-1:0]       num,
    input  logic [aob_pkg::A_W-1:0]       den,
    output logic [aob_pkg::QUOT_W-1:0]    quot,
    output logic                          den_zero
);

    logic [aob_pkg::N_W-1:0]    rem_reg  [aob_pkg::DIV_STAGES-1];
    logic [aob_pkg::A_W-1:0]    den_reg  [aob_pkg::DIV_STAGES];
    logic [aob_pkg::QUOT_W-1:0] quot_reg [aob_pkg::DIV_STAGES];

    for (genvar k = 0; k < aob_pkg::DIV_STAGES; k++) begin : g_stage
        logic [aob_pkg::N_W-1:0]    rem_in;
        logic [aob_pkg::A_W-1:0]    den_in;
        logic [aob_pkg::QUOT_W-1:0] quot_in;
        logic [aob_pkg::N_W-1:0]    shifted;
        logic                       take;
        logic [aob_pkg::QUOT_W-1:0] quot_next;

        if (k == 0) begin : g_first
            assign rem_in  = num;
            assign den_in  = den;
            assign quot_in = '0;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign quot_in = quot_reg[k-1];
        end

        assign shifted   = aob_pkg::N_W'(den_in) << (aob_pkg::QUOT_W - 1 - k);
        assign take      = rem_in >= shifted;
        assign quot_next = {quot_in[aob_pkg::QUOT_W-2:0], take};

        if (k < aob_pkg::DIV_STAGES - 1) begin : g_rem
            logic [aob_pkg::N_W-1:0] rem_next;

            assign rem_next = take ? rem_in - shifted : rem_in;

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= rem_next;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[k]  <= den_in;
                quot_reg[k] <= quot_next;
            end
        end
    end

    assign quot     = quot_reg[aob_pkg::DIV_STAGES-1];
    assign den_zero = den_reg[aob_pkg::DIV_STAGES-1] == '0;

endmodule

// ----- hw/rtl/alpha_over_blend_opacity.sv -----
// Throughput: one pixel pair per cycle while m_ready is high; the pipeline
// holds as a whole only while a result waits in the output register.
// Depth is set by the three front-end stages, the eight-stage divider
// lanes, one quotient bit per stage, and the output register.
// Reset clears the stage valid bits and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
// Alpha-over blend with layer opacity
// Straight-alpha over of a top RGBA8 pixel onto a bottom RGBA8 pixel, three
// divider lanes side by side, a reciprocal multiply for the output alpha and
// a merge stage that forms the result.
// ----------------------------------------------------------------------------
module alpha_over_blend_opacity (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  aob_pkg::chan_t  s_bottom_red,
    input  aob_pkg::chan_t  s_bottom_green,
    input  aob_pkg::chan_t  s_bottom_blue,
    input  aob_pkg::chan_t  s_bottom_alpha,
    input  aob_pkg::chan_t  s_top_red,
    input  aob_pkg::chan_t  s_top_green,
    input  aob_pkg::chan_t  s_top_blue,
    input  aob_pkg::chan_t  s_top_alpha,
    input  aob_pkg::chan_t  s_layer_opacity,
    output logic            m_valid,
    input  logic            m_ready,
    output aob_pkg::chan_t  m_out_red,
    output aob_pkg::chan_t  m_out_green,
    output aob_pkg::chan_t  m_out_blue,
    output aob_pkg::chan_t  m_out_alpha
);

    localparam int LAT    = aob_pkg::FRONT_STAGES + aob_pkg::DIV_STAGES;
    localparam int PROD_W = aob_pkg::RECIP_SHIFT + aob_pkg::QUOT_W;

    logic en;

    aob_pkg::operands_t operands;

    logic [aob_pkg::QUOT_W-1:0] q_red;
    logic [aob_pkg::QUOT_W-1:0] q_green;
    logic [aob_pkg::QUOT_W-1:0] q_blue;
    logic                       zero_red;
    logic                       zero_green;
    logic                       zero_blue;

    aob_pkg::chan_t  alpha_quot;
    aob_pkg::chan_t  alpha_pipe_reg [aob_pkg::DIV_STAGES];

    logic [LAT-1:0]  vld_reg;
    logic [LAT-1:0]  vld_next;
    logic            m_valid_reg;
    aob_pkg::chan_t  out_red_reg;
    aob_pkg::chan_t  out_green_reg;
    aob_pkg::chan_t  out_blue_reg;
    aob_pkg::chan_t  out_alpha_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    aob_front u_front (
        .aclk          (aclk),
        .en            (en),
        .bottom_red    (s_bottom_red),
        .bottom_green  (s_bottom_green),
        .bottom_blue   (s_bottom_blue),
        .bottom_alpha  (s_bottom_alpha),
        .top_red       (s_top_red),
        .top_green     (s_top_green),
        .top_blue      (s_top_blue),
        .top_alpha     (s_top_alpha),
        .layer_opacity (s_layer_opacity),
        .operands      (operands)
    );

    aob_div_lane u_lane_red (
        .aclk     (aclk),
        .en       (en),
        .num      (operands.num_red),
        .den      (operands.alpha_num),
        .quot     (q_red),
        .den_zero (zero_red)
    );

    aob_div_lane u_lane_green (
        .aclk     (aclk),
        .en       (en),
        .num      (operands.num_green),
        .den      (operands.alpha_num),
        .quot     (q_green),
        .den_zero (zero_green)
    );

    aob_div_lane u_lane_blue (
        .aclk     (aclk),
        .en       (en),
        .num      (operands.num_blue),
        .den      (operands.alpha_num),
        .quot     (q_blue),
        .den_zero (zero_blue)
    );

    // The output alpha divides by a constant, so a reciprocal multiply
    // replaces the divider and a delay line keeps it aligned with the lanes.
    assign alpha_quot = aob_pkg::QUOT_W'((PROD_W'(operands.alpha_num)
                                          * PROD_W'(aob_pkg::ALPHA_RECIP))
                                         >> aob_pkg::RECIP_SHIFT);

    always_ff @(posedge aclk) begin
        if (en) begin
            alpha_pipe_reg[0] <= alpha_quot;
            for (int k = 1; k < aob_pkg::DIV_STAGES; k++) begin
                alpha_pipe_reg[k] <= alpha_pipe_reg[k-1];
            end
        end
    end

    assign vld_next = {vld_reg[LAT-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= vld_next;
            m_valid_reg <= vld_reg[LAT-1];
        end
    end

    // A zero alpha numerator forces the colour channels to zero.
    always_ff @(posedge aclk) begin
        if (en) begin
            out_red_reg   <= zero_red   ? '0 : q_red;
            out_green_reg <= zero_green ? '0 : q_green;
            out_blue_reg  <= zero_blue  ? '0 : q_blue;
            out_alpha_reg <= alpha_pipe_reg[aob_pkg::DIV_STAGES-1];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_red   = out_red_reg;
    assign m_out_green = out_green_reg;
    assign m_out_blue  = out_blue_reg;
    assign m_out_alpha = out_alpha_reg;

endmodule

// ----- hw/rtl/aob_checker.sv -----
// ----------------------------------------------------------------------------
// Alpha-over blend port checker
// Watches the top-level ports for handshake and pipeline-fill behavior.
// ----------------------------------------------------------------------------
module aob_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_ready,
    input logic            m_valid,
    input logic            m_ready,
    input aob_pkg::chan_t  m_out_red,
    input aob_pkg::chan_t  m_out_green,
    input aob_pkg::chan_t  m_out_blue,
    input aob_pkg::chan_t  m_out_alpha
);

    // A stalled result stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
    else $error("result dropped while stalled");

    // A stalled result keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_out_red) && $stable(m_out_green)
                                && $stable(m_out_blue) && $stable(m_out_alpha))
    else $error("result changed while stalled");

    // The input side only holds off while a result waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
    else $error("input stalled without a waiting result");

    // After reset, the output valid is checked low at one later cycle, before the pipeline can have filled.
    assert property (@(posedge aclk)
        !aresetn |=> ##10 !m_valid)
    else $error("result too early after reset");

endmodule

bind alpha_over_blend_opacity aob_checker u_checker (.*);
